// ===== rtl/core/rngd_pkg.sv =====
// shared constants and types for the reflected n-ary gray digit block
package rngd_pkg;

  localparam int MAX_DIGITS_DEF = 64;
  localparam int INDEX_BITS_DEF = 60;

  localparam int DIGIT_W = 8;
  localparam int RADIX_W = 9;
  localparam int POS_W   = 7;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 8'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
  localparam logic [POS_W-1:0]   DIGITS_RESET = 7'd8;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/rngd_cell.sv =====
// one digit cell: clears, doubles its base-radix digit with a carry in, or shifts a neighbour digit
module rngd_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rngd_pkg::cell_ctrl_t          ctrl,
  input  logic [rngd_pkg::RADIX_W-1:0]  radix,
  input  logic [rngd_pkg::DIGIT_W-1:0]  d_in,
  input  logic                          c_in,
  input  logic                          en_in,
  output logic [rngd_pkg::DIGIT_W-1:0]  d_out,
  output logic                          c_out,
  output logic                          en_out
);

  logic [rngd_pkg::DIGIT_W-1:0] d_r, d_nxt;
  logic                         c_r, c_nxt;
  logic                         en_r, en_nxt;
  logic [rngd_pkg::RADIX_W-1:0] dbl;
  logic                         ge;
  logic [rngd_pkg::RADIX_W-1:0] diff;

  // 2*d + carry never reaches twice the radix, so one subtract is enough
  assign dbl  = {d_r, c_in};
  assign ge   = (dbl >= radix);
  assign diff = dbl - radix;

  always_comb begin
    d_nxt  = d_r;
    c_nxt  = c_r;
    en_nxt = en_r;
    if (ctrl.clear) begin
      d_nxt  = '0;
      c_nxt  = 1'b0;
      en_nxt = 1'b0;
    end else if (ctrl.conv) begin
      en_nxt = en_in;
      c_nxt  = en_in & ge;
      if (en_in) begin
        d_nxt = ge ? diff[rngd_pkg::DIGIT_W-1:0] : dbl[rngd_pkg::DIGIT_W-1:0];
      end
    end else if (ctrl.shift) begin
      d_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r  <= 1'b0;
      en_r <= 1'b0;
    end else begin
      c_r  <= c_nxt;
      en_r <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out  = d_r;
  assign c_out  = c_r;
  assign en_out = en_r;

endmodule

// ===== rtl/core/reflected_nary_gray_digits.sv =====
// top level: reflected n-ary gray codeword digit generator
// usage
//   in channel: one beat carries a sequence index; taken only while the block is idle
//   out channel: one beat per digit, most significant first; the least significant
//     digit carries last_digit, every beat of a codeword carries out_of_range
//   cfg channel: index 0 radix, index 1 digit count; always ready, write only while idle
// operation
//   a row of MAX_DIGITS cells converts the index to base radix, index bits fed msb
//   first, carries passed cell to cell through registers in a skewed wavefront
//   then the row shifts towards the top cell to drop the unused high digits
//   (the shifting stops once the top digit is in place);
//   a dropped non-zero digit flags out of range
//   then digit_count beats leave from the top cell, gray reflection applied there
// timing
//   the beat is taken in idle, then conversion, alignment, then one beat per cycle
//   while out_ready is high; the next index is taken only after the last beat
//   when out_ready is low the current beat simply holds, nothing is lost
// reset
//   radix 2, digit count 8, block idle, no beat offered
module reflected_nary_gray_digits #(
  parameter int MAX_DIGITS = rngd_pkg::MAX_DIGITS_DEF,
  parameter int INDEX_BITS = rngd_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [INDEX_BITS-1:0]           in_seq_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rngd_pkg::DIGIT_W-1:0]    out_digit_value,
  output logic [rngd_pkg::POS_W-1:0]      out_digit_position,
  output logic                            out_last_digit,
  output logic                            out_out_of_range,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rngd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rngd_pkg::RADIX_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(INDEX_BITS + MAX_DIGITS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_ALIGN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [rngd_pkg::RADIX_W-1:0]  radix_r, radix_nxt;
  logic [rngd_pkg::POS_W-1:0]    digit_count_r, digit_count_nxt;
  logic [INDEX_BITS-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [rngd_pkg::POS_W-1:0]    level_r, level_nxt;
  logic                          oor_r, oor_nxt;
  logic                          flip_r, flip_nxt;

  rngd_pkg::cell_ctrl_t          ctrl;
  logic [rngd_pkg::RADIX_W-1:0]  r_eff;
  logic [rngd_pkg::POS_W-1:0]    k_eff;
  logic [rngd_pkg::DIGIT_W-1:0]  r_max;
  logic [rngd_pkg::DIGIT_W-1:0]  top_d;
  logic [rngd_pkg::DIGIT_W-1:0]  gray_d;
  logic                          is_top;

  logic [rngd_pkg::DIGIT_W-1:0]  d_w  [MAX_DIGITS];
  logic                          c_w  [MAX_DIGITS];
  logic                          en_w [MAX_DIGITS];

  // register values outside the meaningful range are clamped
  always_comb begin
    if (radix_r < rngd_pkg::RADIX_MIN) begin
      r_eff = rngd_pkg::RADIX_MIN;
    end else if (radix_r > rngd_pkg::RADIX_MAX) begin
      r_eff = rngd_pkg::RADIX_MAX;
    end else begin
      r_eff = radix_r;
    end
    if (digit_count_r == '0) begin
      k_eff = rngd_pkg::POS_W'(1);
    end else if (digit_count_r > rngd_pkg::POS_W'(MAX_DIGITS)) begin
      k_eff = rngd_pkg::POS_W'(MAX_DIGITS);
    end else begin
      k_eff = digit_count_r;
    end
  end

  assign r_max = rngd_pkg::DIGIT_W'(r_eff - rngd_pkg::RADIX_W'(1));

  // cell row, cell 0 is the least significant digit
  genvar gi;
  generate
    for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        rngd_cell u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .ctrl   (ctrl),
          .radix  (r_eff),
          .d_in   ('0),
          .c_in   (idx_r[INDEX_BITS-1]),
          .en_in  (cnt_r < CNT_W'(INDEX_BITS)),
          .d_out  (d_w[gi]),
          .c_out  (c_w[gi]),
          .en_out (en_w[gi])
        );
      end else begin : g_rest
        rngd_cell u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .ctrl   (ctrl),
          .radix  (r_eff),
          .d_in   (d_w[gi-1]),
          .c_in   (c_w[gi-1]),
          .en_in  (en_w[gi-1]),
          .d_out  (d_w[gi]),
          .c_out  (c_w[gi]),
          .en_out (en_w[gi])
        );
      end
    end
  endgenerate

  assign top_d  = d_w[MAX_DIGITS-1];
  assign is_top = (level_r == k_eff);

  // leading digit saturates when out of range; reflection mirrors the rest
  always_comb begin
    if (is_top && oor_r) begin
      gray_d = r_max;
    end else if (flip_r) begin
      gray_d = r_max - top_d;
    end else begin
      gray_d = top_d;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    radix_nxt       = radix_r;
    digit_count_nxt = digit_count_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    level_nxt       = level_r;
    oor_nxt         = oor_r;
    flip_nxt        = flip_r;
    ctrl            = '0;

    if (cfg_valid) begin
      if (cfg_index == rngd_pkg::REG_RADIX) begin
        radix_nxt = cfg_data;
      end else if (cfg_index == rngd_pkg::REG_DIGIT_COUNT) begin
        digit_count_nxt = cfg_data[rngd_pkg::POS_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.clear = 1'b1;
          idx_nxt    = in_seq_index;
          cnt_nxt    = '0;
          oor_nxt    = 1'b0;
          flip_nxt   = 1'b0;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        idx_nxt   = idx_r << 1;
        // carry out of the top cell means the index needs more digits
        if (c_w[MAX_DIGITS-1] && en_w[MAX_DIGITS-1]) begin
          oor_nxt = 1'b1;
        end
        if (cnt_r == CNT_W'(INDEX_BITS + MAX_DIGITS - 1)) begin
          level_nxt = rngd_pkg::POS_W'(MAX_DIGITS);
          state_nxt = ST_ALIGN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_ALIGN: begin
        if (is_top) begin
          state_nxt = ST_EMIT;
        end else begin
          ctrl.shift = 1'b1;
          if (top_d != '0) begin
            oor_nxt = 1'b1;
          end
          level_nxt = level_r - rngd_pkg::POS_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          ctrl.shift = 1'b1;
          flip_nxt   = flip_r ^ gray_d[0];
          if (level_r == rngd_pkg::POS_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            level_nxt = level_r - rngd_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      radix_r       <= rngd_pkg::RADIX_RESET;
      digit_count_r <= rngd_pkg::DIGITS_RESET;
      cnt_r         <= '0;
      level_r       <= '0;
      oor_r         <= 1'b0;
      flip_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      radix_r       <= radix_nxt;
      digit_count_r <= digit_count_nxt;
      cnt_r         <= cnt_nxt;
      level_r       <= level_nxt;
      oor_r         <= oor_nxt;
      flip_r        <= flip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = (state_r == ST_EMIT);
  assign out_digit_value    = gray_d;
  assign out_digit_position = level_r;
  assign out_last_digit     = (level_r == rngd_pkg::POS_W'(1));
  assign out_out_of_range   = oor_r;

endmodule
